>>> rtl/core/sae_pkg.sv
package sae_pkg;

  // Fixed port field widths
  localparam int ID_W  = 12;
  localparam int SYM_W = 5;
  localparam int CNT_W = 24;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Sequencer states, one-hot
  typedef enum logic [16:0] {
    S_CLEAR   = 17'h00001,
    S_IDLE    = 17'h00002,
    S_P_RD    = 17'h00004,
    S_P_DATA  = 17'h00008,
    S_CUR_WR  = 17'h00010,
    S_WALK_RD = 17'h00020,
    S_WALK    = 17'h00040,
    S_V_RD    = 17'h00080,
    S_V       = 17'h00100,
    S_V_WR    = 17'h00200,
    S_LINK_RD = 17'h00400,
    S_LINK_WR = 17'h00800,
    S_RED_RD  = 17'h01000,
    S_RED     = 17'h02000,
    S_GAIN_RD = 17'h04000,
    S_GAIN    = 17'h08000,
    S_DONE    = 17'h10000
  } sae_state_t;

  // Add a gain to the running total, sticking at the top value
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] total,
                                               logic [CNT_W-1:0] gain);
    logic [CNT_W-1:0] room;
    room = CNT_MAX - total;
    if (gain >= room) begin
      return CNT_MAX;
    end
    return total + gain;
  endfunction

endpackage

>>> rtl/core/sae_rec_mem.sv
module sae_rec_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 336
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one record, read one record with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/suffix_automaton_extend_unit.sv
// Generalized suffix automaton extender. Each item names an existing state and a
// symbol; the block allocates a new state, walks suffix links setting missing
// transitions, clones a state when the found target has the wrong length, and
// returns the new state id with the running distinct-substring count. Every
// state is one record (transition row, length, suffix link) in a single-port-
// read, single-port-write memory with registered read data, and every change
// after the clearing pass is a read-modify-write of a whole record. A symbol
// outside the alphabet or a full store is answered without touching the store.
// One item is worked at a time; a finished result waits in the output register
// while the next item is accepted. After reset a clearing pass zeroes every
// record of the store before the first item is accepted.
module suffix_automaton_extend_unit import sae_pkg::*; #(
  parameter int MAX_STATES    = 4096,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ID_W-1:0]  from_state,
  input  logic [SYM_W-1:0] symbol,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  new_state,
  output logic [CNT_W-1:0] distinct_count,
  output logic             store_full
);

  localparam int IW       = $clog2(MAX_STATES);
  localparam int SW       = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int GW       = $clog2(MAX_STATES + 1);
  localparam int LEN_LSB  = ALPHABET_SIZE * IW;
  localparam int LINK_LSB = (ALPHABET_SIZE + 1) * IW;
  localparam int RW       = (ALPHABET_SIZE + 2) * IW;

  sae_state_t state;

  logic [IW-1:0]    clr_addr;
  logic [IW-1:0]    used;
  logic [CNT_W-1:0] total;
  logic [IW-1:0]    p;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    v;
  logic [IW-1:0]    w;
  logic [IW-1:0]    link_tgt;
  logic [IW-1:0]    len_cur;
  logic [IW-1:0]    lenp1;
  logic [SW-1:0]    sym_q;
  logic [GW-1:0]    guard;
  logic             clone;
  logic [IW-1:0]    res_new;
  logic             res_full;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;

  logic [IW-1:0] rd_ent;
  logic [IW-1:0] rd_len;
  logic [IW-1:0] rd_link;
  logic [IW-1:0] p_in;
  logic [IW-1:0] gain;
  logic          sym_bad;
  logic          is_full;
  logic          walk_go;
  logic          red_go;

  sae_rec_mem #(
    .DEPTH (MAX_STATES),
    .AW    (IW),
    .DW    (RW)
  ) u_rec_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Decode the record just read
  assign rd_ent  = mem_rdata[sym_q*IW +: IW];
  assign rd_len  = mem_rdata[LEN_LSB +: IW];
  assign rd_link = mem_rdata[LINK_LSB +: IW];

  assign in_ready = (state == S_IDLE);
  assign sym_bad  = 32'(symbol) >= ALPHABET_SIZE;
  assign is_full  = 32'(used) > MAX_STATES - 3;
  assign p_in     = (32'(from_state) >= MAX_STATES) ? IW'(1) : IW'(from_state);
  assign walk_go  = (p != '0) && (rd_ent == '0) && (32'(guard) < MAX_STATES);
  assign red_go   = (p != '0) && (rd_ent == v) && (32'(guard) < MAX_STATES);
  assign gain     = (len_cur >= rd_len) ? (len_cur - rd_len) : '0;

  // Drive memory ports per step
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = p;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_P_RD, S_WALK_RD, S_RED_RD: begin
        mem_re = 1'b1;
      end
      S_P_DATA, S_LINK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur;
      end
      S_CUR_WR: begin
        mem_we                       = 1'b1;
        mem_waddr                    = cur;
        mem_wdata[LEN_LSB +: IW]     = len_cur;
      end
      S_WALK: begin
        mem_we                       = walk_go;
        mem_wdata[sym_q*IW +: IW]    = cur;
      end
      S_V_RD: begin
        mem_re    = 1'b1;
        mem_raddr = v;
      end
      S_V: begin
        mem_we                       = (rd_len != lenp1);
        mem_waddr                    = used + IW'(1);
        mem_wdata[LEN_LSB +: IW]     = lenp1;
      end
      S_V_WR: begin
        mem_we                       = 1'b1;
        mem_waddr                    = v;
        mem_wdata[LINK_LSB +: IW]    = w;
      end
      S_LINK_WR: begin
        mem_we                       = 1'b1;
        mem_waddr                    = cur;
        mem_wdata[LINK_LSB +: IW]    = link_tgt;
      end
      S_RED: begin
        mem_we                       = red_go;
        mem_wdata[sym_q*IW +: IW]    = w;
      end
      S_GAIN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = link_tgt;
      end
      default: begin
      end
    endcase
  end

  // Sequence one item through the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      used      <= IW'(1);
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(MAX_STATES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            sym_q <= SW'(symbol);
            p     <= p_in;
            guard <= '0;
            clone <= 1'b0;
            if (sym_bad) begin
              res_new  <= '0;
              res_full <= 1'b0;
              state    <= S_DONE;
            end else if (is_full) begin
              res_new  <= '0;
              res_full <= 1'b1;
              state    <= S_DONE;
            end else begin
              cur   <= used + IW'(1);
              used  <= used + IW'(1);
              state <= S_P_RD;
            end
          end
        end
        S_P_RD: state <= S_P_DATA;
        S_P_DATA: begin
          len_cur <= rd_len + IW'(1);
          state   <= S_CUR_WR;
        end
        S_CUR_WR: state <= S_WALK_RD;
        S_WALK_RD: state <= S_WALK;
        S_WALK: begin
          if (walk_go) begin
            p     <= rd_link;
            guard <= guard + GW'(1);
            state <= S_WALK_RD;
          end else begin
            lenp1 <= rd_len + IW'(1);
            if (p == '0 || rd_ent == '0) begin
              link_tgt <= IW'(1);
              state    <= S_LINK_RD;
            end else begin
              v     <= rd_ent;
              state <= S_V_RD;
            end
          end
        end
        S_V_RD: state <= S_V;
        S_V: begin
          if (rd_len == lenp1) begin
            link_tgt <= v;
            state    <= S_LINK_RD;
          end else begin
            w        <= used + IW'(1);
            link_tgt <= used + IW'(1);
            used     <= used + IW'(1);
            clone    <= 1'b1;
            guard    <= '0;
            state    <= S_V_WR;
          end
        end
        S_V_WR: state <= S_LINK_RD;
        S_LINK_RD: state <= S_LINK_WR;
        S_LINK_WR: state <= clone ? S_RED_RD : S_GAIN_RD;
        S_RED_RD: state <= S_RED;
        S_RED: begin
          if (red_go) begin
            p     <= rd_link;
            guard <= guard + GW'(1);
            state <= S_RED_RD;
          end else begin
            state <= S_GAIN_RD;
          end
        end
        S_GAIN_RD: state <= S_GAIN;
        S_GAIN: begin
          total    <= sat_add(total, CNT_W'(gain));
          res_new  <= cur;
          res_full <= 1'b0;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            new_state      <= ID_W'(res_new);
            distinct_count <= total;
            store_full     <= res_full;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> total >= $past(total))
    else $error("substring total decreased");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used) <= MAX_STATES - 1)
    else $error("state allocation overran store");

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mem_we)
    else $error("store written while waiting for an item");

endmodule

>>> bench/suffix_automaton_extend_unit_tb.sv
`timescale 1ns / 100ps

import sae_pkg::*;

typedef struct packed {
  logic [ID_W-1:0]  state_id;
  logic [CNT_W-1:0] total;
  logic             full;
} sae_result_t;

class sam_scoreboard;
  localparam int NSTATES = 4096;
  localparam int NSYM    = 26;

  bit [ID_W-1:0] trans [NSTATES][NSYM];
  bit [ID_W-1:0] link [NSTATES];
  int            len [NSTATES];
  int            used;
  bit [CNT_W-1:0] total;
  int            last_id;
  int            full_seen;
  int            mismatches;
  sae_result_t   pending [$];

  function new();
    used = 1;
    total = 0;
    last_id = 1;
    full_seen = 0;
    mismatches = 0;
  endfunction

  // Apply one accepted item to the automaton copy and queue its result
  function void note_item(bit [ID_W-1:0] src, bit [SYM_W-1:0] sym);
    int p, cur, v, w, guard, gain;
    sae_result_t r;
    r.state_id = '0;
    r.total = total;
    r.full = 1'b0;
    if (sym >= NSYM) begin
      pending.push_back(r);
      return;
    end
    if (NSTATES - 1 - used < 2) begin
      r.full = 1'b1;
      full_seen++;
      pending.push_back(r);
      return;
    end
    p = src;
    used++;
    cur = used;
    len[cur] = len[p] + 1;
    // walk links, adding missing transitions
    guard = 0;
    while (p != 0 && trans[p][sym] == 0 && guard < NSTATES) begin
      trans[p][sym] = ID_W'(cur);
      p = link[p];
      guard++;
    end
    if (p == 0 || trans[p][sym] == 0) begin
      link[cur] = ID_W'(1);
    end else begin
      v = trans[p][sym];
      if (len[v] == len[p] + 1) begin
        link[cur] = ID_W'(v);
      end else begin
        // clone v and redirect matching transitions
        used++;
        w = used;
        len[w] = len[p] + 1;
        trans[w] = trans[v];
        link[w] = link[v];
        link[v] = ID_W'(w);
        link[cur] = ID_W'(w);
        guard = 0;
        while (p != 0 && trans[p][sym] == v && guard < NSTATES) begin
          trans[p][sym] = ID_W'(w);
          p = link[p];
          guard++;
        end
      end
    end
    gain = (len[cur] >= len[link[cur]]) ? len[cur] - len[link[cur]] : 0;
    if (gain >= CNT_MAX - total) total = CNT_MAX;
    else total = CNT_W'(total + gain);
    last_id = cur;
    r.state_id = ID_W'(cur);
    r.total = total;
    pending.push_back(r);
  endfunction

  // Compare one result against the oldest pending one
  function void check_result(sae_result_t got);
    sae_result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    e = pending.pop_front();
    if (got.state_id !== e.state_id || got.total !== e.total || got.full !== e.full) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected id=%0d cnt=%0d full=%0b, got id=%0d cnt=%0d full=%0b",
                 e.state_id, e.total, e.full, got.state_id, got.total, got.full);
    end
  endfunction
endclass

module suffix_automaton_extend_unit_tb;
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ID_W-1:0]  from_state = '0;
  logic [SYM_W-1:0] symbol = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ID_W-1:0]  new_state;
  logic [CNT_W-1:0] distinct_count;
  logic             store_full;

  sam_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  suffix_automaton_extend_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .from_state(from_state), .symbol(symbol),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_state(new_state), .distinct_count(distinct_count),
    .store_full(store_full)
  );

  always #4 clk = ~clk;

  // Randomize receiver readiness
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Check accepted results
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{new_state, distinct_count, store_full});
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 200000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Send one item, with optional idle cycles before it
  task automatic send_item(bit [ID_W-1:0] src, bit [SYM_W-1:0] sym);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    from_state <= src;
    symbol <= sym;
    do @(posedge clk); while (!in_ready);
    sb.note_item(src, sym);
  endtask

  task automatic set_phase(int ph);
    case (ph % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
      default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
    endcase
  endtask

  initial begin
    int n, sel;
    bit [ID_W-1:0] src;
    bit [SYM_W-1:0] sym;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: clone, extremes, out-of-alphabet, odd sources
    send_item(12'd1, 5'd0);
    send_item(12'd2, 5'd1);
    send_item(12'd3, 5'd1);
    send_item(ID_W'(sb.last_id), 5'd0);
    send_item(ID_W'(sb.last_id), 5'd1);
    send_item(ID_W'(sb.last_id), 5'd1);
    send_item(12'd1, 5'd25);
    send_item(ID_W'(sb.last_id), 5'd25);
    send_item(12'd1, 5'd26);
    send_item(12'd1, 5'd31);
    send_item(12'd0, 5'd3);
    send_item(12'hFFF, 5'd2);
    send_item(12'd4000, 5'd0);
    send_item(12'hAAA, 5'd31);
    send_item(12'h555, 5'd5);
    send_item(12'd1, 5'd0);
    send_item(ID_W'(sb.last_id), 5'd0);
    send_item(ID_W'(sb.last_id), 5'd0);

    // Random: mostly string extension, some new strings and noise
    n = 0;
    while (n < 1300) begin
      if (n % 200 == 0) set_phase(n / 200);
      sel = $urandom_range(99);
      sym = ($urandom_range(3) == 0) ? SYM_W'($urandom_range(25)) : SYM_W'($urandom_range(3));
      if (sel < 80) src = ID_W'(sb.last_id);
      else if (sel < 88) src = 12'd1;
      else if (sel < 95) src = ID_W'($urandom_range(sb.used, 1));
      else begin
        src = ID_W'($urandom);
        sym = SYM_W'($urandom_range(31));
      end
      send_item(src, sym);
      n++;
    end
    in_valid <= 1'b0;

    // Drain results
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/sae_pkg.sv
rtl/core/sae_rec_mem.sv
rtl/core/suffix_automaton_extend_unit.sv
bench/suffix_automaton_extend_unit_tb.sv
